// ===== rtl/brcs_pkg.sv =====
// Shared types and constants for the block-run to cylinder segment splitter.
// Used by brcs_div and block_run_to_cylinder_segments_core; no dependencies.
`timescale 1ns / 1ps

package brcs_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int BLOCK_SHIFT  = 9;

	// field widths
	localparam int BLK_W    = 12;
	localparam int SPT_W    = 6;
	localparam int SPC_W    = 7;
	localparam int CYL_W    = 8;
	localparam int SEGB_W   = 16;
	localparam int STAT_W   = 2;
	localparam int UNIT_W   = 2;
	localparam int CFG_IDX_W = 2;

	// bound for the remaining blocks after the first piece: (MAX_SEGMENTS-1) * spc
	localparam int LIM_W = 13;

	// divider: one quotient bit per cycle over the full block width
	localparam int DIV_STEPS = BLK_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// reset geometry
	localparam logic [BLK_W-1:0] RST_TOTAL_BLOCKS = BLK_W'(2880);
	localparam logic [SPT_W-1:0] RST_SPT          = SPT_W'(18);
	localparam logic [SPC_W-1:0] RST_SPC          = SPC_W'(36);

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_BADARG  = 2'd1,
		STAT_TOOMANY = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_BLOCKS = 2'd0,
		REG_SPT          = 2'd1,
		REG_SPC          = 2'd2,
		REG_DRIVE_PRES   = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_CYL,
		ST_CNT,
		ST_DIV_SEC,
		ST_DIV_HEAD,
		ST_DIV_SMOD,
		ST_EMIT,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic             start;
		logic [BLK_W-1:0] dividend;
		logic [SPC_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [BLK_W-1:0] quo;
		logic [SPC_W-1:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/brcs_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, dividend shifted out MSB first.
// Depends on brcs_pkg.
`timescale 1ns / 1ps

module brcs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  brcs_pkg::div_req_t req,
	output brcs_pkg::div_rsp_t rsp
);
	import brcs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SPC_W-1:0]     rem_q;
	logic [BLK_W-1:0]     quo_q;
	logic [SPC_W-1:0]     divisor_q;

	logic [SPC_W:0]   trial;
	logic             q_bit;
	logic [SPC_W:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[BLK_W-1]};
		diff  = trial - {1'b0, divisor_q};
		q_bit = (trial >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			// partial remainder stays below the divisor, so the top bit drops out
			rem_q <= q_bit ? diff[SPC_W-1:0] : trial[SPC_W-1:0];
			quo_q <= {quo_q[BLK_W-2:0], q_bit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/block_run_to_cylinder_segments_core.sv =====
// Top level: request check, geometry division, segment emission and output register.
// Depends on brcs_pkg and brcs_div.
`timescale 1ns / 1ps

// Splits one disk transfer request into cylinder-aligned segments. A request is
// taken only while the block is idle. After the argument check, the shared
// one-bit-per-cycle divider runs four times (start / spc, start mod spt, head
// from the cylinder remainder, spc mod spt), with the segment-count check after
// the first run; then one segment per cycle while the output side keeps taking
// items. A bad argument gives its single error item through the check state,
// the error state and the output register. Geometry registers are written
// through the cfg port, always ready; write them only while no request is in
// flight.
module block_run_to_cylinder_segments_core (
	input  logic        clk,
	input  logic        arst_n,
	// config write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [brcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [brcs_pkg::BLK_W-1:0]     cfg_data,
	// request in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // start_block[11:0], block_count[23:12]
	input  logic [2:0]  s_axis_tuser,  // drive_unit[1:0], is_write[2]
	// segment out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // cylinder[7:0], head[8], sector[14:9],
	                                   // segment_blocks[21:15], segment_bytes[37:22], zero
	output logic [2:0]  m_axis_tuser,  // status[1:0], write_op[2]
	output logic        m_axis_tlast
);
	import brcs_pkg::*;

	// geometry registers
	logic [BLK_W-1:0] total_q;
	logic [SPT_W-1:0] spt_q;
	logic [SPC_W-1:0] spc_q;
	logic             present_q;

	// request
	logic [UNIT_W-1:0] unit_q;
	logic              wr_q;
	logic [BLK_W-1:0]  start_q;
	logic [BLK_W-1:0]  count_q;
	logic [BLK_W-1:0]  left_q;

	// segment walk
	logic [CYL_W-1:0]  cyl_q;
	logic [SPC_W-1:0]  crem_q;
	logic              head_q;
	logic [SPT_W-1:0]  smod_q;
	logic [SPT_W-1:0]  cbase_q;
	logic [SPT_W-1:0]  spcmod_q;
	status_t           err_q;

	// output register
	logic              out_valid_q;
	status_t           o_status_q;
	logic [CYL_W-1:0]  o_cyl_q;
	logic              o_head_q;
	logic [SPT_W-1:0]  o_sector_q;
	logic [SPC_W-1:0]  o_blocks_q;
	logic [SEGB_W-1:0] o_bytes_q;
	logic              o_wr_q;
	logic              o_last_q;

	state_t   state_q, state_d;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic             in_acc;
	logic             out_free;
	logic             out_load;
	logic             bad_arg;
	logic             too_many;
	logic [SPC_W-1:0] room1;
	logic [BLK_W:0]   end_blk;
	logic [BLK_W-1:0] rest;
	logic [LIM_W-1:0] lim;
	logic [SPC_W-1:0] room;
	logic [SPC_W-1:0] take;
	logic             seg_last;
	logic [SPT_W:0]   smod_sum;
	logic [SPT_W-1:0] smod_nxt;
	logic [SPT_W-1:0] crem_mod;
	logic [SPT_W-1:0] cbase_init;

	brcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg_ready = 1'b1;
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;

	always_comb begin
		end_blk = {1'b0, start_q} + {1'b0, count_q};
		bad_arg = (unit_q != '0) || !present_q || (count_q == '0) ||
		          (start_q > total_q) || (end_blk > {1'b0, total_q}) ||
		          (spt_q == '0) || (spc_q == '0);

		// pieces > MAX_SEGMENTS when blocks past the first piece exceed
		// (MAX_SEGMENTS-1) full cylinders
		room1    = spc_q - crem_q;
		rest     = count_q - BLK_W'(room1);
		lim      = LIM_W'(spc_q) * LIM_W'(MAX_SEGMENTS - 1);
		too_many = (count_q > BLK_W'(room1)) && (LIM_W'(rest) > lim);

		room     = spc_q - crem_q;
		seg_last = (left_q <= BLK_W'(room));
		take     = seg_last ? left_q[SPC_W-1:0] : room;

		// (cylinder start) mod spt = (start mod spt - crem mod spt) mod spt
		crem_mod   = div_rsp.rem[SPT_W-1:0];
		cbase_init = (smod_q >= crem_mod) ? smod_q - crem_mod
		                                  : smod_q + spt_q - crem_mod;

		// cylinder start mod spt advances by spc mod spt per cylinder
		smod_sum = {1'b0, cbase_q} + {1'b0, spcmod_q};
		smod_nxt = (smod_sum >= {1'b0, spt_q}) ? SPT_W'(smod_sum - {1'b0, spt_q})
		                                       : smod_sum[SPT_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_acc) state_d = ST_CHECK;
			ST_CHECK:    state_d = bad_arg ? ST_ERR : ST_DIV_CYL;
			ST_DIV_CYL:  if (div_rsp.done) state_d = ST_CNT;
			ST_CNT:      state_d = too_many ? ST_ERR : ST_DIV_SEC;
			ST_DIV_SEC:  if (div_rsp.done) state_d = ST_DIV_HEAD;
			ST_DIV_HEAD: if (div_rsp.done) state_d = ST_DIV_SMOD;
			ST_DIV_SMOD: if (div_rsp.done) state_d = ST_EMIT;
			ST_EMIT:     if (out_free && seg_last) state_d = ST_IDLE;
			ST_ERR:      if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready    = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = start_q;
		div_req.divisor  = spc_q;
		unique case (state_q)
			ST_IDLE:     s_axis_tready = 1'b1;
			ST_CHECK:    div_req.start = !bad_arg;
			ST_DIV_CYL:  ;
			ST_CNT: begin
				div_req.start   = !too_many;
				div_req.divisor = SPC_W'(spt_q);
			end
			ST_DIV_SEC: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = BLK_W'(crem_q);
				div_req.divisor  = SPC_W'(spt_q);
			end
			ST_DIV_HEAD: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = BLK_W'(spc_q);
				div_req.divisor  = SPC_W'(spt_q);
			end
			ST_DIV_SMOD: ;
			ST_EMIT:     out_load = out_free;
			ST_ERR:      out_load = out_free;
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			total_q     <= RST_TOTAL_BLOCKS;
			spt_q       <= RST_SPT;
			spc_q       <= RST_SPC;
			present_q   <= 1'b1;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_TOTAL_BLOCKS: total_q   <= cfg_data;
					REG_SPT:          spt_q     <= cfg_data[SPT_W-1:0];
					REG_SPC:          spc_q     <= cfg_data[SPC_W-1:0];
					REG_DRIVE_PRES:   present_q <= cfg_data[0];
					default:          ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			start_q <= s_axis_tdata[11:0];
			count_q <= s_axis_tdata[23:12];
			left_q  <= s_axis_tdata[23:12];
			unit_q  <= s_axis_tuser[1:0];
			wr_q    <= s_axis_tuser[2];
		end
		if (state_q == ST_CHECK)
			err_q <= STAT_BADARG;
		if (state_q == ST_CNT)
			err_q <= STAT_TOOMANY;
		if (div_rsp.done) begin
			case (state_q)
				ST_DIV_CYL: begin
					cyl_q  <= div_rsp.quo[CYL_W-1:0];
					crem_q <= div_rsp.rem;
				end
				ST_DIV_SEC:  smod_q   <= div_rsp.rem[SPT_W-1:0];
				ST_DIV_HEAD: begin
					head_q  <= div_rsp.quo[0];
					cbase_q <= cbase_init;
				end
				ST_DIV_SMOD: spcmod_q <= div_rsp.rem[SPT_W-1:0];
				default:     ;
			endcase
		end
		if (out_load) begin
			o_wr_q <= wr_q;
			if (state_q == ST_EMIT) begin
				o_status_q <= STAT_OK;
				o_cyl_q    <= cyl_q;
				o_head_q   <= head_q;
				o_sector_q <= smod_q + 1'b1;
				o_blocks_q <= take;
				o_bytes_q  <= SEGB_W'({{(SEGB_W){1'b0}}, take} << BLOCK_SHIFT);
				o_last_q   <= seg_last;
				// next piece starts on a cylinder boundary
				left_q  <= left_q - BLK_W'(take);
				cyl_q   <= cyl_q + 1'b1;
				crem_q  <= '0;
				head_q  <= 1'b0;
				smod_q  <= smod_nxt;
				cbase_q <= smod_nxt;
			end else begin
				o_status_q <= err_q;
				o_cyl_q    <= '0;
				o_head_q   <= 1'b0;
				o_sector_q <= '0;
				o_blocks_q <= '0;
				o_bytes_q  <= '0;
				o_last_q   <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, o_bytes_q, o_blocks_q, o_sector_q, o_head_q, o_cyl_q};
	assign m_axis_tuser  = {o_wr_q, o_status_q};
	assign m_axis_tlast  = o_last_q;

endmodule
